>>> design/i2cm_pkg.sv
package i2cm_pkg;

  localparam int unsigned ActionWidth = 3;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned PhaseWidth  = 3;
  localparam int unsigned BitCntWidth = 4;

  localparam logic [ActionWidth-1:0] OP_IDLE  = 3'd0;
  localparam logic [ActionWidth-1:0] OP_START = 3'd1;
  localparam logic [ActionWidth-1:0] OP_STOP  = 3'd2;
  localparam logic [ActionWidth-1:0] OP_SEND  = 3'd3;
  localparam logic [ActionWidth-1:0] OP_WAIT  = 3'd4;
  localparam logic [ActionWidth-1:0] OP_RECV  = 3'd5;
  localparam logic [ActionWidth-1:0] OP_ACK   = 3'd6;
  localparam logic [ActionWidth-1:0] OP_NACK  = 3'd7;

  localparam logic [0:0] REG_DELAY_TICKS = 1'd0;
  localparam logic [0:0] REG_ACK_TRIES   = 1'd1;

  localparam logic [ByteWidth-1:0] DELAY_TICKS_RST = 8'd2;
  localparam logic [ByteWidth-1:0] ACK_TRIES_RST   = 8'd5;
  localparam logic [BitCntWidth-1:0] BITS_PER_BYTE = 4'd8;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_ACK = 1'b1;

  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned OutDataWidth = 16;

  typedef struct packed {
    logic                 scl_pin;
    logic                 sda_released;
    logic                 sda_pin;
    logic                 busy_res;
    logic                 done_res;
    logic                 status;
    logic [ByteWidth-1:0] rx_byte;
  } res_t;

endpackage

>>> design/i2cm_seq.sv
module i2cm_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step_en,
  input  logic [i2cm_pkg::ActionWidth-1:0]    action,
  input  logic [i2cm_pkg::ByteWidth-1:0]      tx_byte,
  input  logic                                sda_level,
  input  logic [i2cm_pkg::ByteWidth-1:0]      delay_ticks,
  input  logic [i2cm_pkg::ByteWidth-1:0]      ack_tries,
  output i2cm_pkg::res_t                      res
);

  typedef struct packed {
    logic [i2cm_pkg::ActionWidth-1:0] op;
    logic [i2cm_pkg::PhaseWidth-1:0]  phase;
    logic [i2cm_pkg::BitCntWidth-1:0] bit_cnt;
    logic [i2cm_pkg::ByteWidth-1:0]   shift;
    logic [i2cm_pkg::ByteWidth-1:0]   slot_cnt;
    logic [i2cm_pkg::ByteWidth-1:0]   tries_left;
    logic                             scl;
    logic                             sda;
    logic                             sda_in;
    logic                             last_status;
    logic [i2cm_pkg::ByteWidth-1:0]   rx_hold;
  } seq_state_t;

  seq_state_t st_r, st_nxt;
  logic       done;
  logic       do_enter;
  logic [i2cm_pkg::PhaseWidth-1:0] enter_p;

  always_comb begin
    st_nxt   = st_r;
    done     = 1'b0;
    do_enter = 1'b0;
    enter_p  = '0;

    // slot bookkeeping
    if (st_r.op == i2cm_pkg::OP_IDLE) begin
      if (action != i2cm_pkg::OP_IDLE) begin
        st_nxt.op      = action;
        st_nxt.bit_cnt = '0;
        if (action == i2cm_pkg::OP_SEND) st_nxt.shift = tx_byte;
        if (action == i2cm_pkg::OP_RECV) begin
          st_nxt.shift  = '0;
          st_nxt.sda_in = 1'b1;
        end
        if (action == i2cm_pkg::OP_WAIT) st_nxt.tries_left = ack_tries;
        do_enter = 1'b1;
        enter_p  = 3'd0;
      end
    end else if (action == i2cm_pkg::OP_IDLE) begin
      if (st_r.slot_cnt > 8'd1) begin
        st_nxt.slot_cnt = st_r.slot_cnt - 8'd1;
      end else begin
        unique case (st_r.op)
          i2cm_pkg::OP_START, i2cm_pkg::OP_STOP, i2cm_pkg::OP_ACK: begin
            if (st_r.phase < 3'd3) begin
              do_enter = 1'b1;
              enter_p  = st_r.phase + 3'd1;
            end else begin
              done = 1'b1;
            end
          end
          i2cm_pkg::OP_NACK: begin
            if (st_r.phase < 3'd2) begin
              do_enter = 1'b1;
              enter_p  = st_r.phase + 3'd1;
            end else begin
              done = 1'b1;
            end
          end
          i2cm_pkg::OP_SEND: begin
            if (st_r.phase < 3'd3) begin
              do_enter = 1'b1;
              enter_p  = st_r.phase + 3'd1;
            end else if (st_r.phase == 3'd3) begin
              st_nxt.bit_cnt = st_r.bit_cnt + 4'd1;
              do_enter = 1'b1;
              enter_p  = (st_nxt.bit_cnt < i2cm_pkg::BITS_PER_BYTE) ? 3'd0 : 3'd4;
            end else begin
              done = 1'b1;
            end
          end
          i2cm_pkg::OP_RECV: begin
            if (st_r.phase < 3'd2) begin
              do_enter = 1'b1;
              enter_p  = st_r.phase + 3'd1;
            end else if (st_r.phase == 3'd2) begin
              st_nxt.shift   = {st_r.shift[i2cm_pkg::ByteWidth-1:1], sda_level};
              st_nxt.bit_cnt = st_r.bit_cnt + 4'd1;
              do_enter = 1'b1;
              enter_p  = (st_nxt.bit_cnt < i2cm_pkg::BITS_PER_BYTE) ? 3'd0 : 3'd3;
            end else begin
              st_nxt.sda_in  = 1'b0;
              st_nxt.rx_hold = st_r.shift;
              done = 1'b1;
            end
          end
          i2cm_pkg::OP_WAIT: begin
            do_enter = 1'b1;
            if (st_r.phase == 3'd0) begin
              enter_p = 3'd1;
            end else if ((st_r.phase == 3'd1) ||
                         (st_r.phase == 3'd2 && st_r.tries_left != 8'd0)) begin
              if (!sda_level) begin
                enter_p = 3'd3;
              end else begin
                st_nxt.tries_left = st_r.tries_left - 8'd1;
                enter_p = 3'd2;
              end
            end else if (st_r.phase == 3'd2) begin
              enter_p = 3'd4;
            end else if (st_r.phase == 3'd3 || st_r.phase == 3'd7) begin
              do_enter = 1'b0;
              done     = 1'b1;
            end else begin
              enter_p = st_r.phase + 3'd1;
            end
          end
          default: ;
        endcase
      end
    end

    if (done) begin
      st_nxt.op          = i2cm_pkg::OP_IDLE;
      st_nxt.phase       = '0;
      st_nxt.last_status = (st_r.op == i2cm_pkg::OP_WAIT && st_r.phase == 3'd7) ?
                           i2cm_pkg::STATUS_NO_ACK : i2cm_pkg::STATUS_OK;
    end

    // pin change at the head of a slot
    if (do_enter) begin
      st_nxt.phase    = enter_p;
      st_nxt.slot_cnt = delay_ticks;
      unique case (st_nxt.op)
        i2cm_pkg::OP_START: begin
          case (enter_p)
            3'd0:    st_nxt.sda = 1'b1;
            3'd1:    st_nxt.scl = 1'b1;
            3'd2:    st_nxt.sda = 1'b0;
            default: st_nxt.scl = 1'b0;
          endcase
        end
        i2cm_pkg::OP_STOP: begin
          case (enter_p)
            3'd0:    st_nxt.scl = 1'b0;
            3'd1:    st_nxt.sda = 1'b0;
            3'd2:    st_nxt.scl = 1'b1;
            default: st_nxt.sda = 1'b1;
          endcase
        end
        i2cm_pkg::OP_SEND: begin
          case (enter_p)
            3'd0: st_nxt.scl = 1'b0;
            3'd1: begin
              st_nxt.sda   = st_nxt.shift[i2cm_pkg::ByteWidth-1];
              st_nxt.shift = {st_nxt.shift[i2cm_pkg::ByteWidth-2:0], 1'b0};
            end
            3'd3:    st_nxt.scl = 1'b1;
            3'd4:    st_nxt.scl = 1'b0;
            default: ;
          endcase
        end
        i2cm_pkg::OP_WAIT: begin
          case (enter_p)
            3'd0: st_nxt.sda_in = 1'b1;
            3'd1: st_nxt.scl = 1'b1;
            3'd3, 3'd4: begin
              st_nxt.sda_in = 1'b0;
              st_nxt.scl    = 1'b0;
            end
            3'd5:    st_nxt.sda = 1'b0;
            3'd6:    st_nxt.scl = 1'b1;
            3'd7:    st_nxt.sda = 1'b1;
            default: ;
          endcase
        end
        i2cm_pkg::OP_RECV: begin
          case (enter_p)
            3'd0: begin
              st_nxt.shift = {st_nxt.shift[i2cm_pkg::ByteWidth-2:0], 1'b0};
              st_nxt.scl   = 1'b0;
            end
            3'd2:    st_nxt.scl = 1'b1;
            3'd3:    st_nxt.scl = 1'b0;
            default: ;
          endcase
        end
        i2cm_pkg::OP_ACK: begin
          case (enter_p)
            3'd0:    st_nxt.sda = 1'b0;
            3'd2:    st_nxt.scl = 1'b1;
            3'd3:    st_nxt.scl = 1'b0;
            default: ;
          endcase
        end
        i2cm_pkg::OP_NACK: begin
          case (enter_p)
            3'd0:    st_nxt.sda = 1'b1;
            3'd1:    st_nxt.scl = 1'b1;
            default: st_nxt.scl = 1'b0;
          endcase
        end
        default: ;
      endcase
    end

    res.scl_pin      = st_nxt.scl;
    res.sda_released = st_nxt.sda_in;
    res.sda_pin      = st_nxt.sda;
    res.busy_res     = (st_nxt.op != i2cm_pkg::OP_IDLE);
    res.done_res     = done;
    res.status       = done ? st_nxt.last_status : i2cm_pkg::STATUS_OK;
    res.rx_byte      = st_nxt.rx_hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{op: i2cm_pkg::OP_IDLE, phase: '0, bit_cnt: '0, shift: '0,
                slot_cnt: '0, tries_left: '0, scl: 1'b1, sda: 1'b1,
                sda_in: 1'b0, last_status: i2cm_pkg::STATUS_OK, rx_hold: '0};
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> design/i2c_master_bit_engine.sv
// channel | dir | tdata (lsb up)                                         | tuser
// in_     | in  | tx_byte[7:0], sda_level[8], zero pad                    | action[2:0]
// out_    | out | scl_pin, sda_released, sda_pin, busy_res, done_res,     | -
//         |     | status, rx_byte[13:6], zero pad                         |
// cfg_    | in  | index 0 delay_ticks, index 1 ack_tries                  | -
//
// one word per cycle sustained while results are taken; an input word passes the
// input register, then the sequencer step into the result register
// synchronous active-low reset: idle, scl and sda high, delay 2, ack tries 5
// a stalled result holds the result register; the input register still takes
// one more word, then in_tready drops until the result is taken
module i2c_master_bit_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [i2cm_pkg::InDataWidth-1:0]    in_tdata,   // tx_byte, sda_level
  input  logic [i2cm_pkg::ActionWidth-1:0]    in_tuser,   // action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [i2cm_pkg::OutDataWidth-1:0]   out_tdata,  // scl_pin .. rx_byte
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [i2cm_pkg::ByteWidth-1:0]      cfg_wdata
);

  logic [i2cm_pkg::ByteWidth-1:0]   delay_ticks_r;
  logic [i2cm_pkg::ByteWidth-1:0]   ack_tries_r;
  logic                             s1_valid_r;
  logic [i2cm_pkg::ActionWidth-1:0] s1_action_r;
  logic [i2cm_pkg::ByteWidth-1:0]   s1_tx_byte_r;
  logic                             s1_sda_r;
  logic                             out_valid_r;
  i2cm_pkg::res_t                   out_res_r;
  i2cm_pkg::res_t                   res;
  logic                             adv;
  logic                             step_en;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign step_en   = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ticks_r <= i2cm_pkg::DELAY_TICKS_RST;
      ack_tries_r   <= i2cm_pkg::ACK_TRIES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cm_pkg::REG_DELAY_TICKS: delay_ticks_r <= cfg_wdata;
        i2cm_pkg::REG_ACK_TRIES:   ack_tries_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_action_r  <= in_tuser;
      s1_tx_byte_r <= in_tdata[i2cm_pkg::ByteWidth-1:0];
      s1_sda_r     <= in_tdata[i2cm_pkg::ByteWidth];
    end
  end

  i2cm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .action      (s1_action_r),
    .tx_byte     (s1_tx_byte_r),
    .sda_level   (s1_sda_r),
    .delay_ticks (delay_ticks_r),
    .ack_tries   (ack_tries_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.rx_byte, out_res_r.status, out_res_r.done_res,
                       out_res_r.busy_res, out_res_r.sda_pin, out_res_r.sda_released,
                       out_res_r.scl_pin};

endmodule

>>> design/i2cm_checker.sv
module i2cm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [i2cm_pkg::OutDataWidth-1:0] out_tdata
);

  // stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // a finished command is no longer busy
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> !out_tdata[3])
    else $error("done with busy set");

  // status only with done
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[4])
    else $error("status without done");

  // empty output stage never blocks input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output stage");

  // no result right after reset
  assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result word after reset");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
